>>> hw/rtl/tmgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tmgs_pkg
// Opcodes, register indexes and fixed sizes of the topic-model token sampler.
// -----------------------------------------------------------------------------
package tmgs_pkg;

    localparam int unsigned MaxTopics  = 64;
    localparam int unsigned MaxDocs    = 1024;
    localparam int unsigned VocabSize  = 4096;
    localparam int unsigned CountBits  = 20;
    localparam int unsigned TotalBits  = 24;
    localparam int unsigned WeightBits = 54;

    typedef enum logic [3:0] {
        OP_SAMPLE     = 4'd0,
        OP_WR_DOC     = 4'd1,
        OP_WR_WORD    = 4'd2,
        OP_WR_TOTAL   = 4'd3,
        OP_WR_ALPHA   = 4'd4,
        OP_WR_PRIOR   = 4'd5,
        OP_RD_DOC     = 4'd6,
        OP_RD_WORD    = 4'd7,
        OP_RD_TOTAL   = 4'd8
    } opcode_t;

    localparam logic [1:0] REG_FREEZE = 2'd0;
    localparam logic [1:0] REG_BETA   = 2'd1;
    localparam logic [1:0] REG_ACTIVE = 2'd2;

endpackage

`default_nettype wire

>>> hw/rtl/topic_model_gibbs_token_sampler.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// topic_model_gibbs_token_sampler
// Collapsed Gibbs resampler of one token topic per transaction, tables in RAM.
// -----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready take one transaction (opcode and operands); out_valid/
//   out_ready return one result per transaction (new_topic, read_value,
//   count_underflow). Registers topic freeze flag, beta_sum, active_topics are
//   written over the APB port at 0x0, 0x4, 0x8; the host must write them only
//   while idle, as the block does not enforce it. Load and read opcodes pass
//   through S_RD0, S_RD1 and S_OUT before the next acceptance. A sample, for
//   each active topic, puts the word factor through a restoring divider (64
//   steps, one bit per cycle) while topics are learned, skipping it when
//   frozen, and then through a weight multiply in S_MUL and S_MUH; the draw
//   walks the weight scratch RAM again. All table RAMs are single port with
//   registered reads, and a whole transaction runs before the next is taken,
//   so no forwarding is needed. Reset clears the control state and registers
//   only; the count tables are undefined until loaded by the host. The result
//   is held in an output register; a stalled receiver holds the block in its
//   result state until the result is taken.
// -----------------------------------------------------------------------------
module topic_model_gibbs_token_sampler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  opcode,
    input  wire logic [9:0]  doc_index,
    input  wire logic [11:0] word_index,
    input  wire logic [5:0]  token_topic,
    input  wire logic [31:0] load_value,
    input  wire logic [31:0] random_draw,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       new_topic,
    output logic [31:0]      read_value,
    output logic             count_underflow
);
    import tmgs_pkg::*;

    localparam int unsigned TB = (MaxTopics > 1) ? $clog2(MaxTopics) : 1;
    localparam int unsigned DB = (MaxDocs > 1) ? $clog2(MaxDocs) : 1;
    localparam int unsigned WB = (VocabSize > 1) ? $clog2(VocabSize) : 1;
    localparam logic [CountBits-1:0] CountMax = '1;
    localparam logic [TotalBits-1:0] TotalMax = '1;
    localparam logic [WeightBits-1:0] WeightCap = {1'b0, {(WeightBits-1){1'b1}}};

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000000000000001,
        S_RD0    = 16'b0000000000000010,
        S_RD1    = 16'b0000000000000100,
        S_DEC    = 16'b0000000000001000,
        S_KRD    = 16'b0000000000010000,
        S_KWAIT  = 16'b0000000000100000,
        S_DIV    = 16'b0000000001000000,
        S_MUL    = 16'b0000000010000000,
        S_WSTORE = 16'b0000000100000000,
        S_THR    = 16'b0000001000000000,
        S_DRD    = 16'b0000010000000000,
        S_DCMP   = 16'b0000100000000000,
        S_INC    = 16'b0001000000000000,
        S_OUT    = 16'b0010000000000000,
        S_MUH    = 16'b0100000000000000,
        S_THH    = 16'b1000000000000000
    } state_t;

    // memories
    logic [CountBits-1:0]  doc_mem   [MaxDocs*MaxTopics];
    logic [CountBits-1:0]  word_mem  [VocabSize*MaxTopics];
    logic [TotalBits-1:0]  total_mem [MaxTopics];
    logic [31:0]           alpha_mem [MaxTopics];
    logic [31:0]           prior_mem [VocabSize*MaxTopics];
    logic [WeightBits-1:0] wt_mem    [MaxTopics];

    state_t state_reg, state_next;
    logic               freeze_reg;
    logic [31:0]        beta_reg;
    logic [6:0]         active_reg;

    // captured transaction
    logic [3:0]  op_reg;
    logic [9:0]  doc_reg;
    logic [11:0] word_reg;
    logic [5:0]  topic_reg;
    logic [31:0] lv_reg;
    logic [31:0] rnd_reg;
    logic [TB-1:0] act_m1_reg;

    logic [TB-1:0] k_reg;
    logic [5:0]    chosen_reg;
    logic          under_reg;
    logic          step_reg;
    logic [31:0]   rv_reg;

    // memory read data
    logic [CountBits-1:0]  doc_q;
    logic [CountBits-1:0]  word_q;
    logic [TotalBits-1:0]  total_q;
    logic [31:0]           alpha_q;
    logic [31:0]           prior_q;
    logic [WeightBits-1:0] wt_q;

    // divider and multiplier
    logic [47:0] num_reg;
    logic [48:0] den_reg;
    logic [48:0] rem_reg;
    logic [31:0] quo_reg;
    logic        ovf_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] fac_reg;
    logic [52:0] dt_reg;
    logic [85:0] prod_reg;
    logic [63:0] sum_reg;
    logic [63:0] run_reg;
    logic [63:0] thr_reg;

    logic in_xfer, out_xfer;
    logic doc_ok, word_ok, top_ok;
    logic [DB+TB-1:0] doc_addr;
    logic [WB+TB-1:0] word_addr;
    logic [TB-1:0]    t_addr, k_sel;
    logic [48:0] rem_sh;
    logic [84:0] prod_shift;
    logic [63:0] mul_lo;
    logic [52:0] mul_hi;
    logic [63:0] thr_lo_prod;
    logic [63:0] thr_hi_prod;

    assign pready   = 1'b1;
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT);
    assign out_xfer  = out_valid && out_ready;

    assign doc_ok  = 32'(doc_reg) < MaxDocs;
    assign word_ok = 32'(word_reg) < VocabSize;
    assign top_ok  = 32'(topic_reg) < MaxTopics;
    assign t_addr  = topic_reg[TB-1:0];

    // address: sampled topic in the first phase, walk index during the loop, chosen topic for the increment
    always_comb
    begin
        priority case (1'b1)
            state_reg[3], state_reg[1], state_reg[2]: k_sel = t_addr;
            state_reg[12]: k_sel = chosen_reg[TB-1:0];
            default: k_sel = k_reg;
        endcase
    end
    assign doc_addr  = {doc_reg[DB-1:0], k_sel};
    assign word_addr = {word_reg[WB-1:0], k_sel};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freeze_reg <= 1'b0;
            beta_reg   <= 32'd65536;
            active_reg <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3:2] == REG_FREEZE) freeze_reg <= pwdata[0];
            if (paddr[3:2] == REG_BETA)   beta_reg   <= pwdata;
            if (paddr[3:2] == REG_ACTIVE) active_reg <= pwdata[6:0];
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_FREEZE: prdata = {31'd0, freeze_reg};
            REG_BETA:   prdata = beta_reg;
            REG_ACTIVE: prdata = {25'd0, active_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // writes to the count memories: load opcodes, decrement and increment
    logic doc_we, word_we, total_we;
    logic [CountBits-1:0] doc_wd, word_wd;
    logic [TotalBits-1:0] total_wd;
    always_comb
    begin
        doc_we = 1'b0; word_we = 1'b0; total_we = 1'b0;
        doc_wd = lv_reg[CountBits-1:0];
        word_wd = lv_reg[CountBits-1:0];
        total_wd = lv_reg[TotalBits-1:0];
        if (state_reg == S_RD0)
        begin
            doc_we   = (op_reg == OP_WR_DOC) && doc_ok && top_ok;
            word_we  = (op_reg == OP_WR_WORD) && word_ok && top_ok;
            total_we = (op_reg == OP_WR_TOTAL) && top_ok;
        end
        else if (state_reg == S_DEC)
        begin
            doc_we = 1'b1;
            doc_wd = (doc_q == '0) ? doc_q : doc_q - 1'b1;
            word_we = !freeze_reg;
            word_wd = (word_q == '0) ? word_q : word_q - 1'b1;
            total_we = !freeze_reg;
            total_wd = (total_q == '0) ? total_q : total_q - 1'b1;
        end
        else if ((state_reg == S_INC) && step_reg)
        begin
            doc_we = 1'b1;
            doc_wd = (doc_q == CountMax) ? doc_q : doc_q + 1'b1;
            word_we = !freeze_reg;
            word_wd = (word_q == CountMax) ? word_q : word_q + 1'b1;
            total_we = !freeze_reg;
            total_wd = (total_q == TotalMax) ? total_q : total_q + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (doc_we) doc_mem[doc_addr] <= doc_wd;
        doc_q <= doc_mem[doc_addr];
    end
    always_ff @(posedge clk)
    begin
        if (word_we) word_mem[word_addr] <= word_wd;
        word_q <= word_mem[word_addr];
    end
    always_ff @(posedge clk)
    begin
        if (total_we) total_mem[k_sel] <= total_wd;
        total_q <= total_mem[k_sel];
    end
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_RD0) && (op_reg == OP_WR_ALPHA) && top_ok)
            alpha_mem[k_sel] <= lv_reg;
        alpha_q <= alpha_mem[k_sel];
    end
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_RD0) && (op_reg == OP_WR_PRIOR) && word_ok && top_ok)
            prior_mem[word_addr] <= lv_reg;
        prior_q <= prior_mem[word_addr];
    end
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WSTORE) wt_mem[k_reg] <= prod_shift[WeightBits-1:0];
        wt_q <= wt_mem[k_reg];
    end

    // restoring divider step and saturated product
    assign rem_sh = {rem_reg[47:0], num_reg[47]};
    assign prod_shift = (prod_reg[84:16] > 69'(WeightCap)) ? 85'(WeightCap)
                                                           : 85'(prod_reg[84:16]);

    // partial products, 32 bits wide at most on one side
    assign mul_lo      = fac_reg * dt_reg[31:0];
    assign mul_hi      = fac_reg * dt_reg[52:32];
    assign thr_lo_prod = rnd_reg * sum_reg[31:0];
    assign thr_hi_prod = rnd_reg * sum_reg[63:32];

    logic last_k;
    assign last_k = (k_reg == act_m1_reg);

    logic [63:0] run_sum;
    assign run_sum = run_reg + 64'(wt_q);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_xfer) state_next = S_RD0;
            S_RD0:    state_next = S_RD1;
            S_RD1:
            begin
                if ((op_reg == OP_SAMPLE) && doc_ok && word_ok && top_ok
                    && (t_addr <= act_m1_reg))
                    state_next = S_DEC;
                else
                    state_next = S_OUT;
            end
            S_DEC:    state_next = S_KRD;
            S_KRD:    state_next = S_KWAIT;
            S_KWAIT:  state_next = freeze_reg ? S_MUL : S_DIV;
            S_DIV:    if (cnt_reg == 6'd0) state_next = S_MUL;
            S_MUL:    state_next = S_MUH;
            S_MUH:    state_next = S_WSTORE;
            S_WSTORE: state_next = last_k ? S_THR : S_KRD;
            S_THR:    state_next = (sum_reg == 64'd0) ? S_INC : S_THH;
            S_THH:    state_next = S_DRD;
            S_DRD:    state_next = S_DCMP;
            S_DCMP:   state_next = ((run_sum > thr_reg) || last_k) ? S_INC : S_DRD;
            S_INC:    if (step_reg) state_next = S_OUT;
            S_OUT:    if (out_xfer) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg <= opcode; doc_reg <= doc_index; word_reg <= word_index;
                topic_reg <= token_topic; lv_reg <= load_value; rnd_reg <= random_draw;
                if (active_reg == 7'd0)
                    act_m1_reg <= '0;
                else if (32'(active_reg) > MaxTopics)
                    act_m1_reg <= TB'(MaxTopics - 1);
                else
                    act_m1_reg <= TB'(active_reg - 7'd1);
                chosen_reg <= token_topic;
                under_reg <= 1'b0;
                rv_reg <= 32'd0;
                k_reg <= '0;
                sum_reg <= 64'd0;
                run_reg <= 64'd0;
                step_reg <= 1'b0;
            end
            S_RD0: ;
            S_RD1:
            begin
                if ((op_reg == OP_RD_DOC) && doc_ok && top_ok) rv_reg <= 32'(doc_q);
                if ((op_reg == OP_RD_WORD) && word_ok && top_ok) rv_reg <= 32'(word_q);
                if ((op_reg == OP_RD_TOTAL) && top_ok) rv_reg <= 32'(total_q);
            end
            S_DEC:
                under_reg <= (doc_q == '0)
                          || (!freeze_reg && ((word_q == '0) || (total_q == '0)));
            S_KRD: ;
            S_KWAIT:
            begin
                num_reg <= (48'(word_q) << 16) + 48'(prior_q);
                den_reg <= {1'b0, 48'({total_q, 16'd0}) + 48'(beta_reg)};
                rem_reg <= '0;
                quo_reg <= '0;
                ovf_reg <= 1'b0;
                cnt_reg <= 6'd63;
                fac_reg <= prior_q;
                dt_reg  <= 53'({doc_q, 16'd0}) + 53'(alpha_q);
            end
            S_DIV:
            begin
                // 48 dividend bits then 16 zero bits give the Q16.16 quotient
                num_reg <= {num_reg[46:0], 1'b0};
                ovf_reg <= ovf_reg | quo_reg[31];
                if (rem_sh >= den_reg)
                begin
                    rem_reg <= rem_sh - den_reg;
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    // quotient in Q16.16 after the final bit
                    if (den_reg == 49'd0)
                        fac_reg <= 32'd0;
                    else if (ovf_reg || quo_reg[31])
                        fac_reg <= 32'hFFFF_FFFF;
                    else
                        fac_reg <= {quo_reg[30:0], (rem_sh >= den_reg)};
                end
            end
            S_MUL:
                prod_reg <= 86'(mul_lo);
            S_MUH:
                prod_reg <= prod_reg + {1'b0, mul_hi, 32'd0};
            S_WSTORE:
            begin
                sum_reg <= sum_reg + 64'(prod_shift[WeightBits-1:0]);
                if (!last_k) k_reg <= k_reg + 1'b1;
                else k_reg <= '0;
            end
            S_THR:
                thr_reg <= {32'd0, thr_lo_prod[63:32]};
            S_THH:
                thr_reg <= thr_reg + thr_hi_prod;
            S_DRD: ;
            S_DCMP:
            begin
                run_reg <= run_sum;
                if (run_sum > thr_reg)
                    chosen_reg <= 6'(k_reg);
            end
            S_INC:
                step_reg <= 1'b1;
            S_OUT: ;
            default: ;
        endcase
        if ((state_reg == S_DCMP) && !(run_sum > thr_reg) && !last_k)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    assign new_topic       = chosen_reg;
    assign read_value      = rv_reg;
    assign count_underflow = under_reg;

    property p_ready_idle;
        @(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready while result held");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && !out_ready) |=> (out_valid && $stable(new_topic));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

    property p_onehot;
        @(posedge clk) disable iff (!rst_n) $onehot(state_reg);
    endproperty
    a_onehot: assert property (p_onehot) else $error("state not one-hot");

endmodule

`default_nettype wire
